// ===== src/rwhp_pkg.sv =====
package rwhp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam int unsigned FMT_BODY_LEN = 16;
  localparam int unsigned HDR_LEN      = 8;
  localparam int unsigned TAG_LEN      = 4;

  // Byte counter within a chunk header or the fmt body.
  localparam int unsigned IDX_W = $clog2(FMT_BODY_LEN);

  localparam logic [IDX_W-1:0] HDR_LAST      = IDX_W'(HDR_LEN - 1);
  localparam logic [IDX_W-1:0] TAG_LAST      = IDX_W'(TAG_LEN - 1);
  localparam logic [IDX_W-1:0] FMT_LAST      = IDX_W'(FMT_BODY_LEN - 1);
  localparam logic [31:0]      FMT_BODY_LEN_W = 32'(FMT_BODY_LEN);
  localparam logic [15:0]      FMT_PCM        = 16'd1;

  // Field offsets within the fmt body.
  localparam logic [IDX_W-1:0] FB_FMT_LO  = IDX_W'(0);
  localparam logic [IDX_W-1:0] FB_FMT_HI  = IDX_W'(1);
  localparam logic [IDX_W-1:0] FB_CH_LO   = IDX_W'(2);
  localparam logic [IDX_W-1:0] FB_CH_HI   = IDX_W'(3);
  localparam logic [IDX_W-1:0] FB_RATE_B0 = IDX_W'(4);
  localparam logic [IDX_W-1:0] FB_RATE_B1 = IDX_W'(5);
  localparam logic [IDX_W-1:0] FB_RATE_B2 = IDX_W'(6);
  localparam logic [IDX_W-1:0] FB_RATE_B3 = IDX_W'(7);
  localparam logic [IDX_W-1:0] FB_BITS_LO = IDX_W'(14);
  localparam logic [IDX_W-1:0] FB_BITS_HI = IDX_W'(15);

  localparam int unsigned OUT_TDATA_W = 104;

  typedef enum logic [3:0] {
    PH_RIFF_HDR,
    PH_RIFF_SKIP,
    PH_WAVE_TAG,
    PH_FMT_HDR,
    PH_FMT_SKIP,
    PH_FMT_BODY,
    PH_FMT_REST,
    PH_DATA_HDR,
    PH_DATA_SKIP,
    PH_PAYLOAD,
    PH_HALTED
  } phase_t;

  typedef enum logic [3:0] {
    ST_PAYLOAD   = 4'd0,
    ST_HDR_OK    = 4'd1,
    ST_NO_RIFF   = 4'd2,
    ST_NOT_WAVE  = 4'd3,
    ST_NO_FMT    = 4'd4,
    ST_SHORT_FMT = 4'd5,
    ST_NOT_PCM   = 4'd6,
    ST_NO_DATA   = 4'd7,
    ST_PAY_END   = 4'd8
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  payload_byte;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [15:0] sample_bits;
  } result_t;

endpackage

// ===== src/rwhp_in_reg.sv =====
module rwhp_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_byte,
  input  logic       in_eos,
  input  logic       take,
  output logic       valid,
  output logic [7:0] byte_q,
  output logic       eos_q
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       eos_r;

  assign in_tready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_byte;
      eos_r  <= in_eos;
    end
  end

  assign valid  = valid_r;
  assign byte_q = byte_r;
  assign eos_q  = eos_r;

endmodule

// ===== src/rwhp_core.sv =====
module rwhp_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  logic [7:0]      byte_in,
  input  logic            eos_in,
  output logic            res_valid,
  output rwhp_pkg::result_t res
);
  import rwhp_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [31:0]      tag_r, tag_nxt;
  logic [31:0]      len_r, len_nxt;
  logic [31:0]      skip_r, skip_nxt;
  logic [15:0]      fmt_r, fmt_nxt;
  logic [15:0]      ch_r, ch_nxt;
  logic [31:0]      rate_r, rate_nxt;
  logic [15:0]      bits_r, bits_nxt;

  // Header byte collection shared by all chunk header phases.
  logic [31:0] hdr_tag;
  logic [31:0] hdr_len;
  logic        hdr_done;
  logic [31:0] skip_dec;
  logic        emit;
  status_t     st;

  always_comb begin
    hdr_tag  = tag_r;
    hdr_len  = len_r;
    if (idx_r < IDX_W'(TAG_LEN)) begin
      hdr_tag = {tag_r[23:0], byte_in};
    end else begin
      hdr_len = len_r | ({24'd0, byte_in} << {idx_r[1:0], 3'b000});
    end
    hdr_done = (idx_r == HDR_LAST);
    skip_dec = skip_r - 32'd1;
  end

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    tag_nxt   = tag_r;
    len_nxt   = len_r;
    skip_nxt  = skip_r;
    fmt_nxt   = fmt_r;
    ch_nxt    = ch_r;
    rate_nxt  = rate_r;
    bits_nxt  = bits_r;
    emit      = 1'b0;
    st        = ST_PAYLOAD;

    if (phase_r == PH_HALTED) begin
      emit = 1'b0;
    end else if (eos_in) begin
      emit      = 1'b1;
      phase_nxt = PH_HALTED;
      unique case (phase_r)
        PH_RIFF_HDR, PH_RIFF_SKIP: st = ST_NO_RIFF;
        PH_WAVE_TAG:               st = ST_NOT_WAVE;
        PH_FMT_HDR, PH_FMT_SKIP:   st = ST_NO_FMT;
        PH_FMT_BODY:               st = ST_SHORT_FMT;
        PH_PAYLOAD:                st = ST_PAY_END;
        default:                   st = ST_NO_DATA;
      endcase
    end else begin
      unique case (phase_r)
        PH_RIFF_HDR, PH_FMT_HDR, PH_DATA_HDR: begin
          tag_nxt = hdr_tag;
          len_nxt = hdr_len;
          idx_nxt = idx_r + IDX_W'(1);
          if (hdr_done) begin
            idx_nxt = '0;
            if (phase_r == PH_RIFF_HDR && hdr_tag == TAG_RIFF) begin
              phase_nxt = PH_WAVE_TAG;
              tag_nxt   = '0;
            end else if (phase_r == PH_FMT_HDR && hdr_tag == TAG_FMT) begin
              if (hdr_len < FMT_BODY_LEN_W) begin
                emit      = 1'b1;
                st        = ST_SHORT_FMT;
                phase_nxt = PH_HALTED;
              end else begin
                phase_nxt = PH_FMT_BODY;
              end
            end else if (phase_r == PH_DATA_HDR && hdr_tag == TAG_DATA) begin
              skip_nxt  = hdr_len;
              phase_nxt = PH_PAYLOAD;
              emit      = 1'b1;
              st        = ST_HDR_OK;
            end else if (hdr_len == '0) begin
              // Empty foreign chunk: straight on to the next header.
              tag_nxt = '0;
              len_nxt = '0;
            end else begin
              skip_nxt = hdr_len;
              if (phase_r == PH_RIFF_HDR) begin
                phase_nxt = PH_RIFF_SKIP;
              end else if (phase_r == PH_FMT_HDR) begin
                phase_nxt = PH_FMT_SKIP;
              end else begin
                phase_nxt = PH_DATA_SKIP;
              end
            end
          end
        end
        PH_RIFF_SKIP, PH_FMT_SKIP, PH_FMT_REST, PH_DATA_SKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == '0) begin
            idx_nxt = '0;
            tag_nxt = '0;
            len_nxt = '0;
            if (phase_r == PH_RIFF_SKIP) begin
              phase_nxt = PH_RIFF_HDR;
            end else if (phase_r == PH_FMT_SKIP) begin
              phase_nxt = PH_FMT_HDR;
            end else begin
              phase_nxt = PH_DATA_HDR;
            end
          end
        end
        PH_WAVE_TAG: begin
          tag_nxt = {tag_r[23:0], byte_in};
          idx_nxt = idx_r + IDX_W'(1);
          if (idx_r == TAG_LAST) begin
            if ({tag_r[23:0], byte_in} != TAG_WAVE) begin
              emit      = 1'b1;
              st        = ST_NOT_WAVE;
              phase_nxt = PH_HALTED;
            end else begin
              phase_nxt = PH_FMT_HDR;
              idx_nxt   = '0;
              tag_nxt   = '0;
              len_nxt   = '0;
            end
          end
        end
        PH_FMT_BODY: begin
          case (idx_r)
            FB_FMT_LO:  fmt_nxt  = {8'd0, byte_in};
            FB_FMT_HI:  fmt_nxt  = fmt_r | {byte_in, 8'd0};
            FB_CH_LO:   ch_nxt   = {8'd0, byte_in};
            FB_CH_HI:   ch_nxt   = ch_r | {byte_in, 8'd0};
            FB_RATE_B0: rate_nxt = {24'd0, byte_in};
            FB_RATE_B1: rate_nxt = rate_r | {16'd0, byte_in, 8'd0};
            FB_RATE_B2: rate_nxt = rate_r | {8'd0, byte_in, 16'd0};
            FB_RATE_B3: rate_nxt = rate_r | {byte_in, 24'd0};
            FB_BITS_LO: bits_nxt = {8'd0, byte_in};
            FB_BITS_HI: bits_nxt = bits_r | {byte_in, 8'd0};
            default:    fmt_nxt  = fmt_r;
          endcase
          idx_nxt = idx_r + IDX_W'(1);
          if (idx_r == FMT_LAST) begin
            idx_nxt = '0;
            if (fmt_nxt != FMT_PCM) begin
              emit      = 1'b1;
              st        = ST_NOT_PCM;
              phase_nxt = PH_HALTED;
            end else if (len_r > FMT_BODY_LEN_W) begin
              skip_nxt  = len_r - FMT_BODY_LEN_W;
              phase_nxt = PH_FMT_REST;
            end else begin
              phase_nxt = PH_DATA_HDR;
              tag_nxt   = '0;
              len_nxt   = '0;
            end
          end
        end
        PH_PAYLOAD: begin
          emit = 1'b1;
          if (skip_r == '0) begin
            st        = ST_PAY_END;
            phase_nxt = PH_HALTED;
          end else begin
            st       = ST_PAYLOAD;
            skip_nxt = skip_dec;
          end
        end
        default: begin
          phase_nxt = PH_HALTED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RIFF_HDR;
      idx_r   <= '0;
      tag_r   <= '0;
      len_r   <= '0;
      skip_r  <= '0;
      fmt_r   <= '0;
      ch_r    <= '0;
      rate_r  <= '0;
      bits_r  <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      tag_r   <= tag_nxt;
      len_r   <= len_nxt;
      skip_r  <= skip_nxt;
      fmt_r   <= fmt_nxt;
      ch_r    <= ch_nxt;
      rate_r  <= rate_nxt;
      bits_r  <= bits_nxt;
    end
  end

  assign res_valid = fire && emit;

  always_comb begin
    res.status        = st;
    res.payload_byte  = (st == ST_PAYLOAD) ? byte_in : 8'd0;
    res.channel_count = ch_nxt;
    res.sample_rate   = rate_nxt;
    res.sample_bits   = bits_nxt;
  end

endmodule

// ===== src/rwhp_out_reg.sv =====
module rwhp_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  rwhp_pkg::result_t   res,
  output logic                can_take,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [rwhp_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [3:0]          out_tuser
);
  import rwhp_pkg::*;

  logic        valid_r, valid_nxt;
  result_t     res_r;
  logic [28:0] frame_r;
  logic [28:0] frame_nxt;

  // Whole bytes per sample times channels.
  assign frame_nxt = res.channel_count * res.sample_bits[15:3];

  assign can_take = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r   <= res;
      frame_r <= frame_nxt;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = res_r.status;
  assign out_tdata  = {3'd0, frame_r, res_r.sample_bits, res_r.sample_rate,
                       res_r.channel_count, res_r.payload_byte};

endmodule

// ===== src/riff_wave_header_parser.sv =====
// Channel  Direction  tdata                      tuser
// in_      slave      [7:0] stream byte          [0] end of stream
// out_     master     payload, format fields     [3:0] status
//
// One stream byte is accepted every cycle while the output is not stalled. Each
// accepted byte is held in the input register; the parse state and the result
// register then load together when that byte is taken from the input register.
// rst_n is synchronous and active low; it returns the parser to the RIFF search.
// A stalled output holds the input register, and in_tready then falls.
module riff_wave_header_parser (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] stream_byte
  input  logic [0:0]   in_tuser,   // [0] end_of_stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // [7:0] payload_byte, [23:8] channel_count, [55:24] sample_rate,
  // [71:56] sample_bits, [100:72] frame_bytes, [103:101] zero
  output logic [rwhp_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [3:0]   out_tuser   // [3:0] status
);
  import rwhp_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_eos;
  logic       can_take;
  logic       fire;
  logic       res_valid;
  result_t    res;

  assign fire = s1_valid && can_take;

  rwhp_in_reg u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .in_eos    (in_tuser[0]),
    .take      (fire),
    .valid     (s1_valid),
    .byte_q    (s1_byte),
    .eos_q     (s1_eos)
  );

  rwhp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .byte_in   (s1_byte),
    .eos_in    (s1_eos),
    .res_valid (res_valid),
    .res       (res)
  );

  rwhp_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (res_valid),
    .res        (res),
    .can_take   (can_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import rwhp_pkg::*;

  localparam int unsigned CLK_HALF        = 6;
  localparam int unsigned RESET_CYCLES    = 12;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned HOLD_OFF_CYCLES = 100;
  localparam int unsigned PAYLOAD_MIN     = 300;
  localparam int unsigned PAYLOAD_MAX     = 380;
  localparam int unsigned FILLER_BYTES    = 360;
  localparam int unsigned OPENING_LEN     = 17;
  localparam int unsigned PRINT_CAP       = 100;

  // How the generated file ends; the first four have well-formed headers.
  typedef enum int {
    END_CLEAN_BYTE, END_CLEAN_EOS, END_EARLY_EOS, END_EMPTY_DATA,
    END_NO_RIFF, END_WAVE_EOS, END_BAD_WAVE, END_NO_FMT, END_SHORT_FMT,
    END_FMT_BODY_EOS, END_NOT_PCM, END_NO_DATA
  } file_ending_t;

  typedef struct {
    logic [7:0] b;
    logic       eos;
  } stream_item_t;

  typedef struct {
    status_t     status;
    logic [7:0]  payload;
    logic [15:0] channels;
    logic [31:0] rate;
    logic [15:0] bits;
    logic [28:0] frame;
  } parser_result_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata   = 8'h00;
  logic [0:0]             in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [3:0]             out_tuser;

  logic holding_off = 1'b0;

  // Opening rows: a zero-length chunk, then a one-byte chunk whose body is
  // skipped. Neither is RIFF, so none of these rows may produce a result.
  logic [7:0] opening_rows [OPENING_LEN] = '{
    8'h4C, 8'h49, 8'h53, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h4A, 8'h55, 8'h4E, 8'h4B, 8'h01, 8'h00, 8'h00, 8'h00,
    8'hFF
  };

  stream_item_t   stream_q[$];
  parser_result_t results_due[$];
  int unsigned    sent_count   = 0;
  int unsigned    fault_count  = 0;

  // Shadow of the parser state.
  phase_t      pr_phase = PH_RIFF_HDR;
  int unsigned pr_count = 0;
  logic [31:0] pr_tag   = '0;
  logic [31:0] pr_len   = '0;
  logic [31:0] pr_left  = '0;
  logic [15:0] pr_code  = '0;
  logic [15:0] pr_ch    = '0;
  logic [31:0] pr_rate  = '0;
  logic [15:0] pr_bits  = '0;

  always #(CLK_HALF) clk = ~clk;

  riff_wave_header_parser i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // ---------------------------------------------------------------- stream

  task automatic put_byte(input logic [7:0] b);
    stream_item_t it;
    it.b   = b;
    it.eos = 1'b0;
    stream_q.push_back(it);
  endtask

  task automatic put_end();
    stream_item_t it;
    it.b   = 8'($urandom);
    it.eos = 1'b1;
    stream_q.push_back(it);
  endtask

  task automatic put_tag(input logic [31:0] t);
    for (int i = 3; i >= 0; i--) put_byte(t[8*i +: 8]);
  endtask

  task automatic put_chunk_header(input logic [31:0] t, input logic [31:0] len);
    put_tag(t);
    for (int i = 0; i < 4; i++) put_byte(len[8*i +: 8]);
  endtask

  // Unknown chunks with random IDs and short bodies, about total bytes in all.
  task automatic put_filler(input int unsigned total);
    int unsigned left, len;
    left = total;
    while (left >= HDR_LEN) begin
      len = $urandom_range(0, 40);
      if (len > left - HDR_LEN) len = left - HDR_LEN;
      put_chunk_header($urandom, len);
      repeat (len) put_byte(8'($urandom));
      left -= HDR_LEN + len;
    end
  endtask

  task automatic build_stream();
    file_ending_t fin;
    int unsigned  r, fmt_len, pay_len, n;
    logic [15:0]  code;
    logic [31:0]  tag;
    logic [127:0] fmt_body;
    r = $urandom_range(0, 19);
    fin = (r < 12) ? file_ending_t'(r % 4) : file_ending_t'(r - 8);

    for (int i = 0; i < OPENING_LEN; i++) put_byte(opening_rows[i]);

    put_filler((fin inside {END_NO_RIFF, END_WAVE_EOS, END_BAD_WAVE}) ?
               FILLER_BYTES : $urandom_range(0, 40));
    if (fin == END_NO_RIFF) begin
      put_end();
      return;
    end
    // The RIFF length is ignored, so any value will do.
    put_chunk_header(TAG_RIFF, $urandom);
    if (fin == END_WAVE_EOS) begin
      tag = TAG_WAVE;
      n = $urandom_range(0, TAG_LEN - 1);
      repeat (n) begin
        put_byte(tag[31:24]);
        tag = tag << 8;
      end
      put_end();
      return;
    end
    if (fin == END_BAD_WAVE) begin
      put_tag(TAG_WAVE ^ (32'h1 << $urandom_range(0, 31)));
      return;
    end
    put_tag(TAG_WAVE);

    put_filler((fin inside {END_NO_FMT, END_SHORT_FMT, END_FMT_BODY_EOS, END_NOT_PCM}) ?
               FILLER_BYTES : $urandom_range(0, 40));
    if (fin == END_NO_FMT) begin
      put_end();
      return;
    end
    fmt_len = (fin == END_SHORT_FMT) ? $urandom_range(0, FMT_BODY_LEN - 1) :
                                       FMT_BODY_LEN + $urandom_range(0, 6);
    put_chunk_header(TAG_FMT, fmt_len);
    if (fin == END_SHORT_FMT) return;

    code = FMT_PCM;
    if (fin == END_NOT_PCM) begin
      code = 16'($urandom);
      if (code == FMT_PCM) code = 16'hFFFF;
    end
    // bits, block align, byte rate, sample rate, channels, format code
    fmt_body = {16'($urandom), 16'($urandom), 32'($urandom), 32'($urandom),
                16'($urandom), code};
    n = (fin == END_FMT_BODY_EOS) ? $urandom_range(0, FMT_BODY_LEN - 1) : FMT_BODY_LEN;
    for (int i = 0; i < n; i++) put_byte(fmt_body[8*i +: 8]);
    if (fin == END_FMT_BODY_EOS) begin
      put_end();
      return;
    end
    if (fin == END_NOT_PCM) return;
    repeat (fmt_len - FMT_BODY_LEN) put_byte(8'($urandom));

    put_filler((fin inside {END_NO_DATA, END_EMPTY_DATA}) ?
               FILLER_BYTES : $urandom_range(0, 40));
    if (fin == END_NO_DATA) begin
      put_end();
      return;
    end
    pay_len = (fin == END_EMPTY_DATA) ? 0 : $urandom_range(PAYLOAD_MIN, PAYLOAD_MAX);
    put_chunk_header(TAG_DATA, pay_len);
    n = (fin == END_EARLY_EOS) ? $urandom_range(0, pay_len - 1) : pay_len;
    repeat (n) put_byte(8'($urandom));
    case (fin)
      END_CLEAN_BYTE: put_byte(8'($urandom));
      END_EMPTY_DATA: begin
        if ($urandom_range(0, 1) == 0) put_end();
        else put_byte(8'($urandom));
      end
      default: put_end();
    endcase
  endtask

  // ------------------------------------------------------------ prediction

  task automatic expect_result(input status_t st, input logic [7:0] b);
    parser_result_t r;
    logic [31:0]    prod;
    prod       = 32'(pr_ch) * 32'(pr_bits >> 3);
    r.status   = st;
    r.payload  = b;
    r.channels = pr_ch;
    r.rate     = pr_rate;
    r.bits     = pr_bits;
    r.frame    = prod[28:0];
    results_due.push_back(r);
  endtask

  task automatic halt_with(input status_t st);
    pr_phase = PH_HALTED;
    expect_result(st, 8'h00);
  endtask

  task automatic start_header(input phase_t ph);
    pr_phase = ph;
    pr_count = 0;
    pr_tag   = '0;
    pr_len   = '0;
  endtask

  // ID bytes arrive first byte most significant, the length little-endian.
  task automatic collect_header_byte(input logic [7:0] b, output logic done);
    if (pr_count < TAG_LEN) pr_tag = {pr_tag[23:0], b};
    else pr_len[8*(pr_count - TAG_LEN) +: 8] = b;
    pr_count++;
    done = (pr_count == HDR_LEN);
    if (done) pr_count = 0;
  endtask

  task automatic skip_chunk(input phase_t hdr_ph, input phase_t skip_ph);
    if (pr_len == 0) begin
      start_header(hdr_ph);
    end else begin
      pr_left  = pr_len;
      pr_phase = skip_ph;
    end
  endtask

  task automatic skip_byte(input phase_t hdr_ph);
    pr_left--;
    if (pr_left == 0) start_header(hdr_ph);
  endtask

  task automatic parse_item(input stream_item_t it);
    logic done;
    done = 1'b0;
    if (pr_phase == PH_HALTED) return;
    if (it.eos) begin
      case (pr_phase)
        PH_RIFF_HDR, PH_RIFF_SKIP: halt_with(ST_NO_RIFF);
        PH_WAVE_TAG:               halt_with(ST_NOT_WAVE);
        PH_FMT_HDR, PH_FMT_SKIP:   halt_with(ST_NO_FMT);
        PH_FMT_BODY:               halt_with(ST_SHORT_FMT);
        PH_PAYLOAD:                halt_with(ST_PAY_END);
        default:                   halt_with(ST_NO_DATA);
      endcase
      return;
    end

    case (pr_phase)
      PH_RIFF_HDR: begin
        collect_header_byte(it.b, done);
        if (done) begin
          if (pr_tag == TAG_RIFF) begin
            pr_phase = PH_WAVE_TAG;
            pr_tag   = '0;
            pr_count = 0;
          end else begin
            skip_chunk(PH_RIFF_HDR, PH_RIFF_SKIP);
          end
        end
      end
      PH_RIFF_SKIP: skip_byte(PH_RIFF_HDR);
      PH_WAVE_TAG: begin
        pr_tag = {pr_tag[23:0], it.b};
        pr_count++;
        if (pr_count == TAG_LEN) begin
          if (pr_tag != TAG_WAVE) halt_with(ST_NOT_WAVE);
          else start_header(PH_FMT_HDR);
        end
      end
      PH_FMT_HDR: begin
        collect_header_byte(it.b, done);
        if (done) begin
          if (pr_tag == TAG_FMT) begin
            if (pr_len < FMT_BODY_LEN_W) begin
              halt_with(ST_SHORT_FMT);
            end else begin
              pr_phase = PH_FMT_BODY;
              pr_count = 0;
            end
          end else begin
            skip_chunk(PH_FMT_HDR, PH_FMT_SKIP);
          end
        end
      end
      PH_FMT_SKIP: skip_byte(PH_FMT_HDR);
      PH_FMT_BODY: begin
        case (pr_count)
          FB_FMT_LO:  pr_code         = {8'h00, it.b};
          FB_FMT_HI:  pr_code[15:8]   = it.b;
          FB_CH_LO:   pr_ch           = {8'h00, it.b};
          FB_CH_HI:   pr_ch[15:8]     = it.b;
          FB_RATE_B0: pr_rate         = {24'h0, it.b};
          FB_RATE_B1: pr_rate[15:8]   = it.b;
          FB_RATE_B2: pr_rate[23:16]  = it.b;
          FB_RATE_B3: pr_rate[31:24]  = it.b;
          FB_BITS_LO: pr_bits         = {8'h00, it.b};
          FB_BITS_HI: pr_bits[15:8]   = it.b;
          default: ;
        endcase
        pr_count++;
        if (pr_count == FMT_BODY_LEN) begin
          pr_count = 0;
          if (pr_code != FMT_PCM) begin
            halt_with(ST_NOT_PCM);
          end else if (pr_len > FMT_BODY_LEN_W) begin
            pr_left  = pr_len - FMT_BODY_LEN_W;
            pr_phase = PH_FMT_REST;
          end else begin
            start_header(PH_DATA_HDR);
          end
        end
      end
      PH_FMT_REST: skip_byte(PH_DATA_HDR);
      PH_DATA_HDR: begin
        collect_header_byte(it.b, done);
        if (done) begin
          if (pr_tag == TAG_DATA) begin
            pr_left  = pr_len;
            pr_phase = PH_PAYLOAD;
            expect_result(ST_HDR_OK, 8'h00);
          end else begin
            skip_chunk(PH_DATA_HDR, PH_DATA_SKIP);
          end
        end
      end
      PH_DATA_SKIP: skip_byte(PH_DATA_HDR);
      PH_PAYLOAD: begin
        if (pr_left == 0) begin
          halt_with(ST_PAY_END);
        end else begin
          pr_left--;
          expect_result(ST_PAYLOAD, it.b);
        end
      end
      default: pr_phase = PH_HALTED;
    endcase
  endtask

  // --------------------------------------------------------------- sender

  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin : feed_stream
    logic accepted;
    logic offer;
    if (rst_n) begin
      accepted = in_tvalid && in_tready;
      if (accepted) begin
        parse_item(stream_q[sent_count]);
        sent_count++;
      end
      // An offered transaction is held until it is taken.
      if (accepted || !in_tvalid) begin
        offer = 1'b0;
        if (sent_count < stream_q.size()) begin
          if (gap_left > 0) begin
            gap_left--;
          end else begin
            offer = 1'b1;
            if (burst_left > 1) begin
              burst_left--;
            end else begin
              burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) :
                                                         $urandom_range(1, 16);
              gap_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) :
                                                         $urandom_range(0, 3);
            end
          end
        end
        in_tvalid <= offer;
        if (offer) begin
          in_tdata <= stream_q[sent_count].b;
          in_tuser <= stream_q[sent_count].eos;
        end
      end
    end
  end

  // ------------------------------------------------------------- receiver

  int unsigned mode_left  = 0;
  int unsigned ready_mode = 0;

  always @(posedge clk) begin : drain_results
    logic take;
    if (mode_left == 0) begin
      mode_left  = $urandom_range(8, 80);
      ready_mode = $urandom_range(0, 2);
    end else begin
      mode_left--;
    end
    case (ready_mode)
      0:       take = 1'b1;
      1:       take = ($urandom_range(0, 1) == 1);
      default: take = ($urandom_range(0, 3) == 0);
    endcase
    out_tready <= take && !holding_off;
  end

  // One long stall from the first predicted result on, so that the result
  // waits at the output and the input backs up. Sampling at the falling
  // edge closes the receiver before that result can be taken.
  initial begin : long_hold
    while (results_due.size() == 0) @(negedge clk);
    holding_off = 1'b1;
    repeat (HOLD_OFF_CYCLES) @(negedge clk);
    holding_off = 1'b0;
  end

  // -------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fault_count < PRINT_CAP)
      $display("%0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    fault_count++;
  endtask

  always @(posedge clk) begin : check_results
    parser_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (results_due.size() == 0) begin
        report_mismatch("transaction with nothing due, status", 32'(out_tuser), 0);
      end else begin
        want = results_due.pop_front();
        if (out_tuser !== want.status)
          report_mismatch("status", 32'(out_tuser), 32'(want.status));
        if (out_tdata[7:0] !== want.payload)
          report_mismatch("payload_byte", 32'(out_tdata[7:0]), 32'(want.payload));
        if (out_tdata[23:8] !== want.channels)
          report_mismatch("channel_count", 32'(out_tdata[23:8]), 32'(want.channels));
        if (out_tdata[55:24] !== want.rate)
          report_mismatch("sample_rate", out_tdata[55:24], want.rate);
        if (out_tdata[71:56] !== want.bits)
          report_mismatch("sample_bits", 32'(out_tdata[71:56]), 32'(want.bits));
        if (out_tdata[100:72] !== want.frame)
          report_mismatch("frame_bytes", 32'(out_tdata[100:72]), 32'(want.frame));
        if (out_tdata[103:101] !== 3'b000)
          report_mismatch("tdata padding", 32'(out_tdata[103:101]), 0);
      end
    end
  end

  // ------------------------------------------------------------ run control

  initial begin : run
    stream_item_t it;
    build_stream();
    // Once the parser has halted these must all be swallowed without a result.
    repeat (6) begin
      it.b   = 8'($urandom);
      it.eos = 1'($urandom_range(0, 1));
      stream_q.push_back(it);
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    while (sent_count < stream_q.size()) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("riff_wave_header_parser: match");
    end else begin
      $display("riff_wave_header_parser: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("riff_wave_header_parser: mismatch");
    $finish;
  end

endmodule
